@@ rtl/core/tcpck_pkg.sv @@
// types, constants and ones-complement helper for the tcp/ip checksum engine
`timescale 1ns / 1ps

package tcpck_pkg;

    localparam int unsigned WordW    = 16;
    localparam int unsigned CountW   = 2;
    localparam logic [3:0]  MinIhl   = 4'd5;
    localparam logic [7:0]  ProtoTcp = 8'd6;

    // header word positions
    localparam logic [WordW-1:0] IdxVerIhl   = 16'd0;
    localparam logic [WordW-1:0] IdxTotalLen = 16'd1;
    localparam logic [WordW-1:0] IdxProto    = 16'd4;
    localparam logic [WordW-1:0] IdxHdrCsum  = 16'd5;
    localparam logic [WordW-1:0] IdxSrcFirst = 16'd6;
    localparam logic [WordW-1:0] IdxDstLast  = 16'd9;
    localparam logic [WordW-1:0] TcpCsumOfs  = 16'd8;
    localparam logic [WordW-1:0] IdxMax      = 16'hffff;

    // snapshot taken on the last word of a packet
    typedef struct packed {
        logic [WordW-1:0] hdr_acc;
        logic [WordW-1:0] seg_acc;
        logic [WordW-1:0] tcp_len;
        logic [WordW-1:0] total;
        logic [WordW+1:0] bytes;
        logic             is_tcp;
    } t_final;

    // one result transfer
    typedef struct packed {
        logic [WordW-1:0] ip_header_sum;
        logic [WordW-1:0] segment_sum;
        logic             is_tcp;
        logic             length_error;
    } t_result;

    function automatic logic [WordW-1:0] oc_add(
        input logic [WordW-1:0] a,
        input logic [WordW-1:0] b
    );
        logic [WordW:0]   s;
        logic [WordW-1:0] r;
        s = {1'b0, a} + {1'b0, b};
        r = s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
        return r;
    endfunction

endpackage

@@ rtl/core/tcp_ip_checksum_engine.sv @@
// top level of the tcp/ip checksum engine: header parse, running sums, result queue
//
// channel  dir  tdata                 tuser                     tlast
// s        in   [15:0] word           [0] odd_tail              last
// m        out  [15:0] ip_header_sum  [0] is_tcp                -
//               [31:16] segment_sum   [1] length_error
//
// one word per cycle while o_s_tready is high; a result leaves through the stages below after its last word
// stage one registers the word, stage two updates the sums, stage three folds in
// the pseudo-header length and feeds a two-entry output queue
// i_rst_n is synchronous and clears all packet state and the queue
// the input stalls only while a last word waits on a finishing stage held by a full queue
`timescale 1ns / 1ps

module tcp_ip_checksum_engine import tcpck_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] word
    input  logic        i_s_tlast,
    input  logic        i_s_tuser,   // [0] odd_tail
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] ip_header_sum, [31:16] segment_sum
    output logic [1:0]  o_m_tuser    // [0] is_tcp, [1] length_error
);

    // input register
    logic             r_s1_valid;
    logic [WordW-1:0] r_s1_word;
    logic             r_s1_last;
    logic             r_s1_odd;

    // packet state
    logic [WordW-1:0] r_word_index;
    logic [3:0]       r_header_words;
    logic [WordW-1:0] r_total_bytes;
    logic [7:0]       r_proto_seen;
    logic [WordW-1:0] r_header_acc;
    logic [WordW-1:0] r_segment_acc;

    // finishing stage
    logic             r_s2_valid;
    t_final           r_s2;

    // output queue
    t_result          r_fifo [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [CountW-1:0] r_cnt;

    logic             s_accept;
    logic             s1_move;
    logic             s2_move;
    logic             m_pop;

    logic [WordW-1:0] w;
    logic [WordW-1:0] idx;
    logic [3:0]       n_header_words;
    logic [WordW-1:0] n_total_bytes;
    logic [7:0]       n_proto_seen;
    logic [3:0]       eff;
    logic [WordW-1:0] hw2;
    logic [WordW-1:0] hw2_tcp;
    logic             in_hdr;
    logic             add_hdr;
    logic             add_seg;
    logic [WordW-1:0] n_header_acc;
    logic [WordW-1:0] n_segment_acc;
    logic [WordW-1:0] n_word_index;
    t_final           n_s2;

    logic [WordW-1:0] seg_p6;
    logic [WordW-1:0] seg_sum;
    t_result          res;
    t_result          head;

    // handshakes
    assign s2_move    = r_s2_valid && (r_cnt != CountW'(2));
    assign s1_move    = r_s1_valid && (!r_s1_last || !r_s2_valid || s2_move);
    assign o_s_tready = !r_s1_valid || !r_s1_last || !r_s2_valid || (r_cnt != CountW'(2));
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign m_pop      = o_m_tvalid && i_m_tready;

    // header parse and running sums
    always_comb begin
        w   = (r_s1_last && r_s1_odd) ? {r_s1_word[15:8], 8'h00} : r_s1_word;
        idx = r_word_index;

        n_header_words = (idx == IdxVerIhl)   ? w[11:8]  : r_header_words;
        n_total_bytes  = (idx == IdxTotalLen) ? w        : r_total_bytes;
        n_proto_seen   = (idx == IdxProto)    ? w[7:0]   : r_proto_seen;

        eff     = (n_header_words < MinIhl) ? MinIhl : n_header_words;
        hw2     = {11'd0, eff, 1'b0};
        hw2_tcp = hw2 + TcpCsumOfs;
        in_hdr  = idx < hw2;
        add_hdr = in_hdr && (idx != IdxHdrCsum);
        add_seg = in_hdr ? ((idx >= IdxSrcFirst) && (idx <= IdxDstLast))
                         : (idx != hw2_tcp);

        n_header_acc  = add_hdr ? oc_add(r_header_acc, w) : r_header_acc;
        n_segment_acc = add_seg ? oc_add(r_segment_acc, w) : r_segment_acc;
        n_word_index  = (idx == IdxMax) ? idx : idx + 16'd1;

        n_s2.hdr_acc = n_header_acc;
        n_s2.seg_acc = n_segment_acc;
        n_s2.tcp_len = n_total_bytes - {10'd0, eff, 2'b00};
        n_s2.total   = n_total_bytes;
        n_s2.bytes   = {1'b0, idx, 1'b0} + 18'd2 - {17'd0, r_s1_odd};
        n_s2.is_tcp  = (n_proto_seen == ProtoTcp);
    end

    // pseudo-header fold and result
    always_comb begin
        seg_p6  = oc_add(r_s2.seg_acc, {8'd0, ProtoTcp});
        seg_sum = oc_add(seg_p6, r_s2.tcp_len);

        res.ip_header_sum = ~r_s2.hdr_acc;
        res.segment_sum   = r_s2.is_tcp ? ~seg_sum : '0;
        res.is_tcp        = r_s2.is_tcp;
        res.length_error  = (r_s2.bytes != {2'b00, r_s2.total});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_word <= i_s_tdata;
            r_s1_last <= i_s_tlast;
            r_s1_odd  <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index   <= '0;
            r_header_words <= '0;
            r_total_bytes  <= '0;
            r_proto_seen   <= '0;
            r_header_acc   <= '0;
            r_segment_acc  <= '0;
        end else if (s1_move) begin
            if (r_s1_last) begin
                r_word_index   <= '0;
                r_header_words <= '0;
                r_total_bytes  <= '0;
                r_proto_seen   <= '0;
                r_header_acc   <= '0;
                r_segment_acc  <= '0;
            end else begin
                r_word_index   <= n_word_index;
                r_header_words <= n_header_words;
                r_total_bytes  <= n_total_bytes;
                r_proto_seen   <= n_proto_seen;
                r_header_acc   <= n_header_acc;
                r_segment_acc  <= n_segment_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move && r_s1_last) begin
            r_s2_valid <= 1'b1;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_last) begin
            r_s2 <= n_s2;
        end
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (s2_move) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (m_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({s2_move, m_pop})
                2'b10:   r_cnt <= r_cnt + CountW'(1);
                2'b01:   r_cnt <= r_cnt - CountW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign head       = r_fifo[r_rd_ptr];
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {head.segment_sum, head.ip_header_sum};
    assign o_m_tuser  = {head.length_error, head.is_tcp};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != CountW'(3))
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CountW'(2)) |-> !s2_move)
        else $error("push into full output queue");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_s1_last && r_s2_valid && !s2_move))
        else $error("input stalled without a blocked last word");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_last) |=> (r_word_index == '0) && r_s2_valid)
        else $error("packet state not restarted after last word");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !m_pop)
        else $error("pop from empty output queue");
`endif

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for tcp_ip_checksum_engine: stimulus, predictor, result check
`timescale 1ns / 1ps

module tb_top import tcpck_pkg::*; ();

    localparam int unsigned IdleLimit  = 4000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned LongWords  = 64;
    localparam int unsigned RandWords  = 1100;

    typedef enum logic [1:0] {RxOpen, RxCoin, RxPeriodic, RxSparse} rx_pattern_e;
    typedef enum logic [1:0] {FillRandom, FillZero, FillOnes} fill_e;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = 16'h0000;   // [15:0] word
    logic        i_s_tlast  = 1'b0;
    logic        i_s_tuser  = 1'b0;       // [0] odd_tail
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;               // [15:0] ip_header_sum, [31:16] segment_sum
    logic [1:0]  o_m_tuser;               // [0] is_tcp, [1] length_error

    tcp_ip_checksum_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted packet state
    logic [15:0] word_cnt   = '0;
    logic [3:0]  ihl_seen   = '0;
    logic [15:0] total_seen = '0;
    logic [7:0]  proto_byte = '0;
    logic [15:0] hdr_sum    = '0;
    logic [15:0] seg_sum    = '0;

    t_result     due_results[$];
    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned burst_left     = 0;
    bit          gaps_on        = 1'b1;
    int unsigned hold_cycles    = 0;
    rx_pattern_e rx_mode        = RxOpen;
    int unsigned rx_left        = 0;
    int unsigned idle_cycles    = 0;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned s;
        s = int'(a) + int'(b);
        s = (s & 32'hffff) + (s >> 16);
        return s[15:0];
    endfunction

    task automatic accumulate_word(input logic [15:0] w_in, input logic lst, input logic tail);
        logic [15:0] w;
        logic        odd;
        int unsigned idx;
        int unsigned hdr_words;
        int unsigned nbytes;
        logic [15:0] tcp_len;
        logic [15:0] seg;
        t_result     r;
        odd = lst && tail;
        w = odd ? {w_in[15:8], 8'h00} : w_in;
        idx = word_cnt;
        if (idx == IdxVerIhl) begin
            ihl_seen = w[11:8];
        end else if (idx == IdxTotalLen) begin
            total_seen = w;
        end else if (idx == IdxProto) begin
            proto_byte = w[7:0];
        end
        hdr_words = (ihl_seen < MinIhl) ? MinIhl : ihl_seen;
        if (idx < 2 * hdr_words) begin
            if (idx != IdxHdrCsum) begin
                hdr_sum = ones_add(hdr_sum, w);
            end
            if (idx >= IdxSrcFirst && idx <= IdxDstLast) begin
                seg_sum = ones_add(seg_sum, w);
            end
        end else if (idx != 2 * hdr_words + TcpCsumOfs) begin
            seg_sum = ones_add(seg_sum, w);
        end
        if (word_cnt < IdxMax) begin
            word_cnt = word_cnt + 16'd1;
        end
        if (lst) begin
            nbytes  = 2 * (idx + 1) - (odd ? 1 : 0);
            tcp_len = total_seen - 16'(4 * hdr_words);
            seg     = ones_add(ones_add(seg_sum, 16'(ProtoTcp)), tcp_len);
            r.ip_header_sum = ~hdr_sum;
            r.is_tcp        = (proto_byte == ProtoTcp);
            r.segment_sum   = r.is_tcp ? ~seg : 16'h0000;
            r.length_error  = (nbytes != int'(total_seen));
            due_results.push_back(r);
            word_cnt   = '0;
            ihl_seen   = '0;
            total_seen = '0;
            proto_byte = '0;
            hdr_sum    = '0;
            seg_sum    = '0;
        end
    endtask

    // input prediction and output check
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                accumulate_word(i_s_tdata, i_s_tlast, i_s_tuser);
            end
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[15:0], o_m_tdata[31:16], o_m_tuser[0], o_m_tuser[1]};
                if (due_results.size() == 0) begin
                    $display("%0t unexpected result transfer %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.ip_header_sum !== want.ip_header_sum) begin
                        $display("%0t ip_header_sum expected %h actual %h",
                                 $time, want.ip_header_sum, got.ip_header_sum);
                        mismatch_count++;
                    end
                    if (got.segment_sum !== want.segment_sum) begin
                        $display("%0t segment_sum expected %h actual %h",
                                 $time, want.segment_sum, got.segment_sum);
                        mismatch_count++;
                    end
                    if (got.is_tcp !== want.is_tcp) begin
                        $display("%0t is_tcp expected %b actual %b",
                                 $time, want.is_tcp, got.is_tcp);
                        mismatch_count++;
                    end
                    if (got.length_error !== want.length_error) begin
                        $display("%0t length_error expected %b actual %b",
                                 $time, want.length_error, got.length_error);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_pattern_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end else begin
            rx_left--;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RxOpen:     i_m_tready <= 1'b1;
                RxCoin:     i_m_tready <= 1'($urandom_range(0, 1));
                RxPeriodic: i_m_tready <= (rx_left % 5) >= 2;
                default:    i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on transfers of either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [15:0] w, input logic lst, input logic tail);
        int unsigned gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(1, 12);
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        i_s_tlast  <= lst;
        i_s_tuser  <= tail;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_packet(input logic [3:0] ihl, input int unsigned nwords,
                               input logic [15:0] total, input logic [7:0] proto,
                               input logic odd, input fill_e fill);
        logic [15:0] w;
        logic        lst;
        for (int unsigned i = 0; i < nwords; i++) begin
            case (fill)
                FillZero: w = 16'h0000;
                FillOnes: w = 16'hffff;
                default:  w = 16'($urandom);
            endcase
            if (i == IdxVerIhl) begin
                w = {4'h4, ihl, w[7:0]};
            end else if (i == IdxTotalLen) begin
                w = total;
            end else if (i == IdxProto) begin
                w[7:0] = proto;
            end
            lst = (i == nwords - 1);
            send_word(w, lst, lst ? odd : 1'($urandom));
        end
    endtask

    // consistent packet: total length matches the bytes sent
    task automatic send_good(input logic [3:0] ihl, input int unsigned payload,
                             input logic [7:0] proto, input logic odd, input fill_e fill);
        int unsigned n;
        n = 2 * ihl + payload + odd;
        send_packet(ihl, n, 16'(2 * n - odd), proto, odd, fill);
    endtask

    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        send_good(4'd5, 0, ProtoTcp, 1'b0, FillZero);
        send_good(4'd6, 1, ProtoTcp, 1'b1, FillOnes);
        send_good(4'd5, 0, 8'hff, 1'b0, FillOnes);
    endtask

    task automatic test_short_header();
        send_packet(4'd4, 11, 16'd22, ProtoTcp, 1'b0, FillRandom);
        send_packet(4'd0, 10, 16'd19, ProtoTcp, 1'b0, FillRandom);
    endtask

    task automatic test_truncated();
        send_packet(4'd5, 1, 16'd0, ProtoTcp, 1'b1, FillRandom);
        send_packet(4'd5, 3, 16'd5, ProtoTcp, 1'b0, FillRandom);
    endtask

    task automatic test_length_below_header();
        send_packet(4'd5, 10, 16'd8, ProtoTcp, 1'b0, FillRandom);
    endtask

    task automatic test_random_packets();
        int unsigned start;
        int unsigned pkt;
        int unsigned n;
        int unsigned pick;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic        odd;
        start = words_sent;
        pkt = 0;
        while (words_sent - start < RandWords) begin
            if (pkt % 16 == 0) begin
                gaps_on = $urandom_range(0, 2) != 0;
            end
            pkt++;
            pick  = $urandom_range(0, 9);
            odd   = 1'($urandom);
            proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : ProtoTcp;
            if (pick <= 6) begin
                ihl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(5, 7));
                send_good(ihl, $urandom_range(0, 12), proto, odd, FillRandom);
            end else if (pick == 7) begin
                send_packet(4'($urandom), $urandom_range(1, 12), 16'($urandom),
                            8'($urandom), odd, FillRandom);
            end else if (pick == 8) begin
                n = $urandom_range(10, 24);
                send_packet(4'($urandom_range(5, 6)), n,
                            16'(2 * n - odd + $urandom_range(1, 3)), proto, odd, FillRandom);
            end else begin
                n = $urandom_range(10, 20);
                send_packet(4'($urandom_range(0, 4)), n, 16'(2 * n - odd), proto, odd,
                            FillRandom);
            end
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off while short packets keep coming, so the input stalls
    task automatic test_output_stall();
        gaps_on = 1'b0;
        hold_cycles = HoldCycles;
        repeat (12) begin
            send_packet(4'($urandom), $urandom_range(1, 3), 16'($urandom), ProtoTcp,
                        1'($urandom), FillRandom);
        end
        gaps_on = 1'b1;
    endtask

    // one packet longer than the random ones, sent without gaps
    task automatic test_long_stream();
        gaps_on = 1'b0;
        send_packet(4'd5, LongWords, 16'hffff, ProtoTcp, 1'b1, FillRandom);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_short_header();
        test_truncated();
        test_length_below_header();
        wait_for_results();
        test_random_packets();
        wait_for_results();
        test_output_stall();
        wait_for_results();
        test_long_stream();
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
